// File: rtl/core/aesp_pkg.sv
// Shared types and constants for the ANSI escape stream parser.
`default_nettype none

package aesp_pkg;

   localparam int MAX_PARAMS = 16;
   localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   localparam logic [15:0] CH_ESC   = 16'h001b;
   localparam logic [15:0] CH_BEL   = 16'h0007;
   localparam logic [15:0] CH_LF    = 16'h000a;
   localparam logic [15:0] CH_CR    = 16'h000d;
   localparam logic [15:0] CH_BS    = 16'h0008;
   localparam logic [15:0] CH_TAB   = 16'h0009;
   localparam logic [15:0] CH_SPACE = 16'h0020;
   localparam logic [15:0] CH_LBRK  = 16'h005b;
   localparam logic [15:0] CH_RBRK  = 16'h005d;
   localparam logic [15:0] CH_BSLSH = 16'h005c;
   localparam logic [15:0] CH_SEMI  = 16'h003b;
   localparam logic [15:0] CH_ZERO  = 16'h0030;
   localparam logic [15:0] CH_NINE  = 16'h0039;
   localparam logic [15:0] CH_FIN_LO = 16'h0040;
   localparam logic [15:0] CH_FIN_HI = 16'h007e;

   // Final bytes of a CSI sequence, low seven bits.
   localparam logic [6:0] FIN_SGR = 7'h6d;
   localparam logic [6:0] FIN_EL  = 7'h4b;
   localparam logic [6:0] FIN_ED  = 7'h4a;
   localparam logic [6:0] FIN_CUU = 7'h41;
   localparam logic [6:0] FIN_CUD = 7'h42;
   localparam logic [6:0] FIN_CUF = 7'h43;
   localparam logic [6:0] FIN_CUB = 7'h44;

   localparam logic [4:0] COLOR_DEFAULT = 5'd16;

   typedef enum logic [3:0] {
      EV_PRINT     = 4'd0,
      EV_NEWLINE   = 4'd1,
      EV_RETURN    = 4'd2,
      EV_BACKSPACE = 4'd3,
      EV_TAB       = 4'd4,
      EV_EL_END    = 4'd5,
      EV_EL_START  = 4'd6,
      EV_EL_ALL    = 4'd7,
      EV_CLEAR     = 4'd8,
      EV_ED_END    = 4'd9,
      EV_CUR_UP    = 4'd10,
      EV_CUR_DOWN  = 4'd11,
      EV_CUR_RIGHT = 4'd12,
      EV_CUR_LEFT  = 4'd13
   } event_kind_type;

   typedef enum logic [2:0] {
      PH_GROUND  = 3'd0,
      PH_ESC     = 3'd1,
      PH_CSI     = 3'd2,
      PH_OSC     = 3'd3,
      PH_OSC_ESC = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_STEP     = 3'd1,
      ST_FINAL    = 3'd2,
      ST_SGR_CODE = 3'd3,
      ST_SGR_SEL  = 3'd4,
      ST_SGR_IDX  = 3'd5
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic final_evt;
      logic sgr_reset;
      logic sgr_code;
      logic ext_start;
      logic sel_ok;
      logic idx_apply;
   } ctl_cmd_type;

   typedef struct packed {
      logic step_event;
      logic step_final;
      logic final_is_sgr;
      logic seq_empty;
      logic out_free;
      logic walk_done;
      logic code_ext;
      logic sel_is5;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/aesp_ctrl.sv
// Sequencing state machine of the ANSI escape stream parser.
`default_nettype none

module aesp_ctrl
   import aesp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  dp_status_type      status,
   output ctl_cmd_type        cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.step_final) begin
               state_in = ST_FINAL;
            end else if (!status.step_event || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (status.final_is_sgr) begin
               state_in = status.seq_empty ? ST_IDLE : ST_SGR_CODE;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SGR_CODE: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end else if (status.code_ext) begin
               state_in = ST_SGR_SEL;
            end
         end
         ST_SGR_SEL: begin
            state_in = status.sel_is5 ? ST_SGR_IDX : ST_SGR_CODE;
         end
         ST_SGR_IDX: begin
            state_in = ST_SGR_CODE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_STEP: begin
            cmd.step = status.step_final || !status.step_event || status.out_free;
         end
         ST_FINAL: begin
            if (status.final_is_sgr) begin
               cmd.sgr_reset = status.seq_empty;
            end else begin
               cmd.final_evt = status.out_free;
            end
         end
         ST_SGR_CODE: begin
            if (!status.walk_done) begin
               cmd.ext_start = status.code_ext;
               cmd.sgr_code  = !status.code_ext;
            end
         end
         ST_SGR_SEL: begin
            cmd.sel_ok = status.sel_is5;
         end
         ST_SGR_IDX: begin
            cmd.idx_apply = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/aesp_dpath.sv
// Datapath of the ANSI escape stream parser: phase, parameters, attributes, result.
`default_nettype none

module aesp_dpath
   import aesp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  ctl_cmd_type        cmd,
   output dp_status_type      status,
   input  wire logic [15:0]   req_char_code,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [3:0]         rsp_event_kind,
   output logic [15:0]        rsp_char_code_res,
   output logic [15:0]        rsp_move_count,
   output logic [4:0]         rsp_fg_color,
   output logic [4:0]         rsp_bg_color,
   output logic               rsp_bold,
   output logic               rsp_underline
);

   // Item and parser state.
   logic [15:0]     char_ff;
   phase_type       phase_ff,     phase_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic            seq_empty_ff, seq_empty_in;
   logic            dropping_ff,  dropping_in;
   logic [15:0]     cur_val_ff,   cur_val_in;
   logic            cur_ok_ff,    cur_ok_in;
   logic            cur_bad_ff,   cur_bad_in;
   logic [6:0]      final_ff,     final_in;
   logic [CNT_W-1:0] idx_ff,      idx_in;
   logic            ext_bg_ff,    ext_bg_in;

   // Attributes.
   logic [4:0]      fg_ff,        fg_in;
   logic [4:0]      bg_ff,        bg_in;
   logic            bold_ff,      bold_in;
   logic            uline_ff,     uline_in;

   // Parameter store.
   logic [15:0]     pval_ff [MAX_PARAMS];
   logic            pok_ff  [MAX_PARAMS];
   logic            wr_en;
   logic [IDX_W-1:0] wr_idx;

   // Result register.
   logic            out_valid_ff, out_valid_in;
   event_kind_type  out_kind_ff,  out_kind_in;
   logic [15:0]     out_char_ff,  out_char_in;
   logic [15:0]     out_count_ff, out_count_in;
   logic [4:0]      out_fg_ff,    out_fg_in;
   logic [4:0]      out_bg_ff,    out_bg_in;
   logic            out_bold_ff,  out_bold_in;
   logic            out_uline_ff, out_uline_in;
   logic            out_write;

   // Decode of the held unit.
   logic            is_digit;
   logic            is_final;
   logic            ground_event;
   event_kind_type  ground_kind;
   logic [19:0]     acc_wide;
   logic [15:0]     acc_sat;
   logic            out_free;

   // Parameter read at the walk index.
   logic [15:0]     rd_val;
   logic            rd_ok;
   logic [15:0]     rd_num;
   logic [CNT_W:0]  idx_plus2;
   logic            count_below_max;

   // Event from a non-SGR final.
   logic            fin_emit;
   event_kind_type  fin_kind;
   logic [15:0]     fin_count;

   assign is_digit = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign is_final = (char_ff >= CH_FIN_LO) && (char_ff <= CH_FIN_HI);
   assign acc_wide = {1'b0, cur_val_ff, 3'b000} + {3'b000, cur_val_ff, 1'b0}
                     + {16'd0, char_ff[3:0] - CH_ZERO[3:0]};
   assign acc_sat  = (acc_wide > 20'd65535) ? 16'hffff : acc_wide[15:0];
   assign out_free = !out_valid_ff || !rsp_stall;

   assign rd_val    = pval_ff[idx_ff[IDX_W-1:0]];
   assign rd_ok     = pok_ff[idx_ff[IDX_W-1:0]];
   assign rd_num    = rd_ok ? rd_val : 16'd0;
   assign idx_plus2 = {1'b0, idx_ff} + (CNT_W + 1)'(2);
   assign count_below_max = count_ff < CNT_W'(MAX_PARAMS);

   always_comb begin
      ground_event = 1'b1;
      ground_kind  = EV_PRINT;
      priority if (char_ff == CH_LF) begin
         ground_kind = EV_NEWLINE;
      end else if (char_ff == CH_CR) begin
         ground_kind = EV_RETURN;
      end else if (char_ff == CH_BS) begin
         ground_kind = EV_BACKSPACE;
      end else if (char_ff == CH_TAB) begin
         ground_kind = EV_TAB;
      end else if (char_ff >= CH_SPACE) begin
         ground_kind = EV_PRINT;
      end else begin
         ground_event = 1'b0;
      end
   end

   // Events of erase and cursor finals use the first parameter.
   always_comb begin
      fin_emit  = 1'b1;
      fin_kind  = EV_EL_END;
      fin_count = 16'd0;
      unique case (final_ff)
         FIN_EL: begin
            if (rd_num == 16'd0)      fin_kind = EV_EL_END;
            else if (rd_num == 16'd1) fin_kind = EV_EL_START;
            else                      fin_kind = EV_EL_ALL;
         end
         FIN_ED: begin
            if (rd_num == 16'd2 || rd_num == 16'd3) fin_kind = EV_CLEAR;
            else if (rd_num == 16'd0)               fin_kind = EV_ED_END;
            else                                    fin_emit = 1'b0;
         end
         FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB: begin
            fin_count = rd_ok ? rd_val : 16'd1;
            unique case (final_ff)
               FIN_CUU: fin_kind = EV_CUR_UP;
               FIN_CUD: fin_kind = EV_CUR_DOWN;
               FIN_CUF: fin_kind = EV_CUR_RIGHT;
               default: fin_kind = EV_CUR_LEFT;
            endcase
         end
         default: begin
            fin_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      status.step_event   = (phase_ff == PH_GROUND) && ground_event;
      status.step_final   = (phase_ff == PH_CSI) && is_final;
      status.final_is_sgr = final_ff == FIN_SGR;
      status.seq_empty    = seq_empty_ff;
      status.out_free     = out_free;
      status.walk_done    = idx_ff >= count_ff;
      status.code_ext     = rd_ok && (rd_val == 16'd38 || rd_val == 16'd48)
                            && (idx_plus2 < {1'b0, count_ff});
      status.sel_is5      = rd_num == 16'd5;
   end

   // Parser state, parameter commit and attribute update.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      seq_empty_in = seq_empty_ff;
      dropping_in  = dropping_ff;
      cur_val_in   = cur_val_ff;
      cur_ok_in    = cur_ok_ff;
      cur_bad_in   = cur_bad_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      ext_bg_in    = ext_bg_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      bold_in      = bold_ff;
      uline_in     = uline_ff;
      wr_en        = 1'b0;
      wr_idx       = IDX_W'(count_ff - CNT_W'(1));
      out_write    = 1'b0;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_count_in = out_count_ff;

      if (cmd.step) begin
         unique case (phase_ff)
            PH_GROUND: begin
               if (char_ff == CH_ESC) begin
                  phase_in = PH_ESC;
               end else if (ground_event) begin
                  out_write    = 1'b1;
                  out_kind_in  = ground_kind;
                  out_char_in  = (ground_kind == EV_PRINT) ? char_ff : 16'd0;
                  out_count_in = 16'd0;
               end
            end
            PH_ESC: begin
               if (char_ff == CH_LBRK) begin
                  phase_in     = PH_CSI;
                  count_in     = CNT_W'(1);
                  seq_empty_in = 1'b1;
                  dropping_in  = 1'b0;
                  cur_val_in   = 16'd0;
                  cur_ok_in    = 1'b0;
                  cur_bad_in   = 1'b0;
               end else if (char_ff == CH_RBRK) begin
                  phase_in = PH_OSC;
               end else begin
                  phase_in = PH_GROUND;
               end
            end
            PH_CSI: begin
               if (is_final) begin
                  // Close the open parameter, then run the final from the store.
                  phase_in = PH_GROUND;
                  wr_en    = 1'b1;
                  final_in = char_ff[6:0];
                  idx_in   = '0;
               end else begin
                  seq_empty_in = 1'b0;
                  if (!dropping_ff) begin
                     if (char_ff == CH_SEMI) begin
                        if (count_below_max) begin
                           wr_en      = 1'b1;
                           count_in   = count_ff + CNT_W'(1);
                           cur_val_in = 16'd0;
                           cur_ok_in  = 1'b0;
                           cur_bad_in = 1'b0;
                        end else begin
                           dropping_in = 1'b1;
                        end
                     end else if (is_digit) begin
                        cur_val_in = acc_sat;
                        if (!cur_bad_ff) cur_ok_in = 1'b1;
                     end else begin
                        cur_bad_in = 1'b1;
                        cur_ok_in  = 1'b0;
                     end
                  end
               end
            end
            PH_OSC, PH_OSC_ESC: begin
               if (phase_ff == PH_OSC_ESC && char_ff == CH_BSLSH) begin
                  phase_in = PH_GROUND;
               end else if (char_ff == CH_BEL) begin
                  phase_in = PH_GROUND;
               end else if (char_ff == CH_ESC) begin
                  phase_in = PH_OSC_ESC;
               end else begin
                  phase_in = PH_OSC;
               end
            end
            default: begin
               phase_in = PH_GROUND;
            end
         endcase
      end

      if (cmd.final_evt && fin_emit) begin
         out_write    = 1'b1;
         out_kind_in  = fin_kind;
         out_char_in  = 16'd0;
         out_count_in = fin_count;
      end

      if (cmd.sgr_reset) begin
         fg_in    = COLOR_DEFAULT;
         bg_in    = COLOR_DEFAULT;
         bold_in  = 1'b0;
         uline_in = 1'b0;
      end

      if (cmd.sgr_code) begin
         idx_in = idx_ff + CNT_W'(1);
         if (rd_ok) begin
            if (rd_val == 16'd0) begin
               fg_in    = COLOR_DEFAULT;
               bg_in    = COLOR_DEFAULT;
               bold_in  = 1'b0;
               uline_in = 1'b0;
            end else if (rd_val == 16'd1) begin
               bold_in = 1'b1;
            end else if (rd_val == 16'd22) begin
               bold_in = 1'b0;
            end else if (rd_val == 16'd4) begin
               uline_in = 1'b1;
            end else if (rd_val == 16'd24) begin
               uline_in = 1'b0;
            end else if (rd_val >= 16'd30 && rd_val <= 16'd37) begin
               fg_in = {2'b00, rd_val[2:0] - 3'd6};
            end else if (rd_val >= 16'd90 && rd_val <= 16'd97) begin
               fg_in = {2'b01, rd_val[2:0] - 3'd2};
            end else if (rd_val == 16'd39) begin
               fg_in = COLOR_DEFAULT;
            end else if (rd_val >= 16'd40 && rd_val <= 16'd47) begin
               bg_in = {2'b00, rd_val[2:0]};
            end else if (rd_val >= 16'd100 && rd_val <= 16'd107) begin
               bg_in = {2'b01, rd_val[2:0] - 3'd4};
            end else if (rd_val == 16'd49) begin
               bg_in = COLOR_DEFAULT;
            end
         end
      end

      if (cmd.ext_start) begin
         ext_bg_in = rd_val == 16'd48;
         idx_in    = idx_ff + CNT_W'(1);
      end

      if (cmd.sel_ok) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      if (cmd.idx_apply) begin
         idx_in = idx_ff + CNT_W'(1);
         if (rd_num < 16'd16) begin
            if (ext_bg_ff) bg_in = {1'b0, rd_num[3:0]};
            else           fg_in = {1'b0, rd_num[3:0]};
         end
      end
   end

   // The result carries the attributes as they stand when it is formed.
   always_comb begin
      out_fg_in    = fg_ff;
      out_bg_in    = bg_ff;
      out_bold_in  = bold_ff;
      out_uline_in = uline_ff;
      out_valid_in = out_valid_ff;
      if (out_write) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GROUND;
         count_ff     <= '0;
         seq_empty_ff <= 1'b1;
         dropping_ff  <= 1'b0;
         cur_ok_ff    <= 1'b0;
         cur_bad_ff   <= 1'b0;
         idx_ff       <= '0;
         fg_ff        <= COLOR_DEFAULT;
         bg_ff        <= COLOR_DEFAULT;
         bold_ff      <= 1'b0;
         uline_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         seq_empty_ff <= seq_empty_in;
         dropping_ff  <= dropping_in;
         cur_ok_ff    <= cur_ok_in;
         cur_bad_ff   <= cur_bad_in;
         idx_ff       <= idx_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         bold_ff      <= bold_in;
         uline_ff     <= uline_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) char_ff <= req_char_code;
      cur_val_ff <= cur_val_in;
      final_ff   <= final_in;
      ext_bg_ff  <= ext_bg_in;
      if (wr_en) begin
         pval_ff[wr_idx] <= cur_val_ff;
         pok_ff[wr_idx]  <= cur_ok_ff;
      end
      if (out_write) begin
         out_kind_ff  <= out_kind_in;
         out_char_ff  <= out_char_in;
         out_count_ff <= out_count_in;
         out_fg_ff    <= out_fg_in;
         out_bg_ff    <= out_bg_in;
         out_bold_ff  <= out_bold_in;
         out_uline_ff <= out_uline_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_char_code_res = out_char_ff;
   assign rsp_move_count    = out_count_ff;
   assign rsp_fg_color      = out_fg_ff;
   assign rsp_bg_color      = out_bg_ff;
   assign rsp_bold          = out_bold_ff;
   assign rsp_underline     = out_uline_ff;

endmodule

`default_nettype wire

// File: rtl/core/ansi_escape_stream_parser.sv
// Top level of the ANSI escape stream parser: controller and datapath.
`default_nettype none

// This block follows terminal output one UTF-16 code unit per item through
// ground, escape, CSI and OSC phases. Printable units and LF, CR, BS and TAB
// produce an event item at once; a CSI sequence collects up to MAX_PARAMS
// semicolon-separated decimal parameters, each saturating at 65535, and its
// final byte produces an erase or cursor-move event, or updates the stored
// bold, underline and palette colors (SGR). OSC strings end on BEL or
// ESC-backslash and produce nothing. Every event item carries the attributes
// that are current when it is formed. An ordinary unit is accepted in the
// idle state and processed in the step state, and no new unit is taken until
// the block is back in idle. A CSI final then passes through the final state,
// in which the event is formed from the first parameter in the parameter
// registers, the processing step having just closed the open parameter into
// them. A non-empty SGR final then walks those registers, one parameter at a
// time, with an extra selector step for each 38 or 48 code that has two
// parameters after it but is not the 5;n indexed color form. A result sits in
// an output register; the next item is still taken while it waits, and only
// an item that would itself produce a result, or a CSI final other than SGR,
// waits for that register to drain. Reset is synchronous.

module ansi_escape_stream_parser
   import aesp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [15:0]   req_char_code,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [3:0]         rsp_event_kind,
   output logic [15:0]        rsp_char_code_res,
   output logic [15:0]        rsp_move_count,
   output logic [4:0]         rsp_fg_color,
   output logic [4:0]         rsp_bg_color,
   output logic               rsp_bold,
   output logic               rsp_underline
);

   // Commands from the controller and status back from the datapath.
   ctl_cmd_type   cmd;
   dp_status_type status;

   aesp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aesp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_char_code_res (rsp_char_code_res),
      .rsp_move_count    (rsp_move_count),
      .rsp_fg_color      (rsp_fg_color),
      .rsp_bg_color      (rsp_bg_color),
      .rsp_bold          (rsp_bold),
      .rsp_underline     (rsp_underline)
   );

endmodule

`default_nettype wire
